[hw/rtl/tt8_pkg.sv]
// ----------------------------------------------------------------------------
// tt8_pkg
// Shared types for the tag text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package tt8_pkg;

  localparam int unsigned MAX_BYTES = 3;

  typedef logic [7:0] byte_t;

  // One decoded item: up to three UTF-8 bytes plus the frame end flag.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [1:0]                cnt;
    logic                      last;
  } cmd_t;

endpackage

[hw/rtl/tt8_ifs.sv]
// ----------------------------------------------------------------------------
// tt8 channel interfaces
// Valid/ready channels for frame bytes, UTF-8 results and the capacity write.
// ----------------------------------------------------------------------------
interface tt8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source(output valid, in_byte, frame_last, input ready);
  modport sink(input valid, in_byte, frame_last, output ready);
endinterface

interface tt8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       text_end;

  modport source(output valid, out_byte, byte_valid, text_end, input ready);
  modport sink(input valid, out_byte, byte_valid, text_end, output ready);
endinterface

interface tt8_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] output_capacity;

  modport source(output valid, output_capacity, input ready);
  modport sink(input valid, output_capacity, output ready);
endinterface

[hw/rtl/tt8_front.sv]
// ----------------------------------------------------------------------------
// tt8_front
// Accepts frame bytes, tracks encoding and byte-order state, and turns each
// item into a command of up to three UTF-8 bytes under the capacity limit.
// ----------------------------------------------------------------------------
module tt8_front (
  input  logic             clk,
  input  logic             rst_n,
  tt8_in_if.sink           in_chan,
  tt8_cfg_if.sink          cfg_chan,
  input  logic             q_full,
  output logic             q_push,
  output tt8_pkg::cmd_t    q_cmd
);

  typedef enum logic [1:0] {
    PH_ENC  = 2'd0,
    PH_BOM  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LATIN1 = 2'd0,
    KIND_UTF16  = 2'd1,
    KIND_RAW    = 2'd2
  } kind_t;

  localparam logic [7:0] CODE_LATIN1   = 8'h00;
  localparam logic [7:0] CODE_UTF16    = 8'h01;
  localparam logic [7:0] CODE_UTF16_BE = 8'h02;
  localparam logic [7:0] BOM_FF        = 8'hff;
  localparam logic [7:0] BOM_FE        = 8'hfe;
  localparam logic [7:0] CAP_RESET     = 8'd160;

  phase_t             phase_r, phase_nxt;
  kind_t              kind_r, kind_nxt;
  logic               le_r, le_nxt;
  tt8_pkg::byte_t     held_r, held_nxt;
  logic               held_vld_r, held_vld_nxt;
  logic               stop_r, stop_nxt;
  logic [7:0]         wcount_r, wcount_nxt;
  logic [7:0]         cap_r;

  logic               accept;
  tt8_pkg::byte_t     b;
  logic [15:0]        unit;
  logic [15:0]        cp;
  logic               emit;
  logic               skip;
  logic [1:0]         cp_cnt;
  logic [9:0]         cp_end;
  tt8_pkg::cmd_t      cmd;

  assign accept           = in_chan.valid && in_chan.ready;
  assign in_chan.ready    = !q_full;
  assign cfg_chan.ready   = 1'b1;
  assign b                = in_chan.in_byte;
  assign unit             = le_r ? {b, held_r} : {held_r, b};

  always_comb begin
    if (cp < 16'h0080) begin
      cp_cnt = 2'd1;
    end else if (cp < 16'h0800) begin
      cp_cnt = 2'd2;
    end else begin
      cp_cnt = 2'd3;
    end
    cp_end = {2'b00, wcount_r} + {8'd0, cp_cnt};
  end

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    le_nxt       = le_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    stop_nxt     = stop_r;
    wcount_nxt   = wcount_r;
    cp           = {8'd0, b};
    emit         = 1'b0;
    skip         = 1'b0;

    unique case (phase_r)
      PH_ENC: begin
        le_nxt       = 1'b0;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
        stop_nxt     = 1'b0;
        wcount_nxt   = '0;
        if (b == CODE_UTF16 || b == CODE_UTF16_BE) begin
          kind_nxt  = KIND_UTF16;
          phase_nxt = PH_BOM;
        end else begin
          kind_nxt  = (b == CODE_LATIN1) ? KIND_LATIN1 : KIND_RAW;
          phase_nxt = PH_BODY;
        end
      end
      PH_BOM, PH_BODY: begin
        if (!stop_r) begin
          if (kind_r == KIND_UTF16) begin
            if (!held_vld_r) begin
              held_nxt     = b;
              held_vld_nxt = 1'b1;
            end else begin
              held_vld_nxt = 1'b0;
              if (phase_r == PH_BOM) begin
                phase_nxt = PH_BODY;
                if (held_r == BOM_FF && b == BOM_FE) begin
                  le_nxt = 1'b1;
                  skip   = 1'b1;
                end else if (held_r == BOM_FE && b == BOM_FF) begin
                  skip = 1'b1;
                end
              end
              cp = unit;
              if (!skip) begin
                if (unit == 16'd0) begin
                  stop_nxt = 1'b1;
                end else begin
                  emit = 1'b1;
                end
              end
            end
          end else begin
            if (b == 8'd0) begin
              stop_nxt = 1'b1;
            end else if ({2'b00, wcount_r} + 10'd1 < {2'b00, cap_r}) begin
              emit = 1'b1;
              if (kind_r != KIND_LATIN1) begin
                cp = {8'd0, b} & 16'h007f;
              end
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_ENC;
      end
    endcase

    if (emit && cp_end >= {2'b00, cap_r}) begin
      emit = 1'b0;
    end
    if (emit) begin
      wcount_nxt = cp_end[7:0];
    end

    if (in_chan.frame_last) begin
      phase_nxt    = PH_ENC;
      kind_nxt     = KIND_LATIN1;
      le_nxt       = 1'b0;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
      stop_nxt     = 1'b0;
      wcount_nxt   = '0;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.last = in_chan.frame_last;
    if (emit) begin
      cmd.cnt = cp_cnt;
      unique case (cp_cnt)
        2'd1: begin
          cmd.data[0] = cp[7:0];
        end
        2'd2: begin
          cmd.data[0] = 8'hc0 | cp[13:6];
          cmd.data[1] = 8'h80 | {2'b00, cp[5:0]};
        end
        default: begin
          cmd.data[0] = 8'he0 | {4'd0, cp[15:12]};
          cmd.data[1] = 8'h80 | {2'b00, cp[11:6]};
          cmd.data[2] = 8'h80 | {2'b00, cp[5:0]};
        end
      endcase
    end
    if (kind_r != KIND_LATIN1 && kind_r != KIND_UTF16 && emit) begin
      cmd.data[0] = b;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (emit || in_chan.frame_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ENC;
      kind_r     <= KIND_LATIN1;
      le_r       <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      stop_r     <= 1'b0;
      wcount_r   <= '0;
      cap_r      <= CAP_RESET;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        kind_r     <= kind_nxt;
        le_r       <= le_nxt;
        held_r     <= held_nxt;
        held_vld_r <= held_vld_nxt;
        stop_r     <= stop_nxt;
        wcount_r   <= wcount_nxt;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        cap_r <= cfg_chan.output_capacity;
      end
    end
  end

endmodule

[hw/rtl/tt8_queue.sv]
// ----------------------------------------------------------------------------
// tt8_queue
// Small command queue between the decode front and the byte emitter.
// ----------------------------------------------------------------------------
module tt8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tt8_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_vld,
  output tt8_pkg::cmd_t head_cmd
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tt8_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign head_vld = (count_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("push without pop did not grow queue");

endmodule

[hw/rtl/tt8_back.sv]
// ----------------------------------------------------------------------------
// tt8_back
// Takes commands from the queue and emits their bytes one per cycle while
// the output is ready, with the frame end flag on each frame's final result.
// ----------------------------------------------------------------------------
module tt8_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_vld,
  input  tt8_pkg::cmd_t q_cmd,
  output logic          q_pop,
  tt8_out_if.source     out_chan
);

  tt8_pkg::cmd_t cur_r, cur_nxt;
  logic          cur_vld_r, cur_vld_nxt;
  logic [1:0]    idx_r, idx_nxt;

  logic          done;
  logic          fire;
  logic          load;

  assign done = (cur_r.cnt == 2'd0) || (idx_r == cur_r.cnt - 2'd1);
  assign fire = cur_vld_r && out_chan.ready;
  assign load = !cur_vld_r || (fire && done);
  assign q_pop = load && q_vld;

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (load) begin
      cur_vld_nxt = q_vld;
      cur_nxt     = q_cmd;
      idx_nxt     = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_chan.out_byte = cur_r.data[0];
      2'd1:    out_chan.out_byte = cur_r.data[1];
      2'd2:    out_chan.out_byte = cur_r.data[2];
      default: out_chan.out_byte = '0;
    endcase
  end

  assign out_chan.valid      = cur_vld_r;
  assign out_chan.byte_valid = (cur_r.cnt != 2'd0);
  assign out_chan.text_end   = cur_r.last && done;

  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r && cur_r.cnt == 2'd0 |-> cur_r.last)
    else $error("empty command without frame end");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r && cur_r.cnt != 2'd0 |-> idx_r < cur_r.cnt)
    else $error("byte index beyond command length");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && out_chan.text_end |=> idx_r == 2'd0)
    else $error("byte index not cleared after frame end");

endmodule

[hw/rtl/tag_text_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// tag_text_to_utf8_transcoder
// Converts tag text frames (Latin-1, UTF-16 with optional byte-order mark,
// or raw bytes) to a UTF-8 byte stream limited by an output capacity.
// ----------------------------------------------------------------------------
// The front decoder accepts one frame byte per cycle whenever the command
// queue has room; each byte yields 0 to 3 UTF-8 results, and the output
// channel delivers one result per cycle while its ready is high. In UTF-16
// each character takes two items. The first result of an item is held in
// the queue memory, then in the emitter's current-command register, before
// it can be taken.
// A frame's final byte that yields no data produces one bare end marker.
// The capacity register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module tag_text_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  tt8_in_if.sink     in_chan,
  tt8_out_if.source  out_chan,
  tt8_cfg_if.sink    cfg_chan
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_vld;
  tt8_pkg::cmd_t push_cmd;
  tt8_pkg::cmd_t head_cmd;

  tt8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  tt8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_cmd (head_cmd)
  );

  tt8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
